// File: hdl/dda_pkg.sv
// Shared constants and controller/datapath interface types for the DDA line rasterizer.
package dda_pkg;

  localparam int COORD_INT_BITS_DEF  = 6;
  localparam int COORD_FRAC_BITS_DEF = 4;
  localparam int STEP_FRAC_BITS_DEF  = 16;

  localparam int MAX_RESULTS = 63;
  localparam int PIX_W       = 7;
  localparam int COLOR_W     = 32;

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit;
  } dda_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic last;
    logic out_free;
  } dda_status_t;

endpackage

// File: hdl/dda_datapath.sv
// Datapath: endpoint rounding, two restoring divider lanes, accumulators and output register.
module dda_datapath #(
  parameter int COORD_INT_BITS  = dda_pkg::COORD_INT_BITS_DEF,
  parameter int COORD_FRAC_BITS = dda_pkg::COORD_FRAC_BITS_DEF,
  parameter int STEP_FRAC_BITS  = dda_pkg::STEP_FRAC_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  dda_pkg::dda_cmd_t                         cmd_i,
  output dda_pkg::dda_status_t                      status_o,
  input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] start_x_i,
  input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] start_y_i,
  input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] end_x_i,
  input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] end_y_i,
  input  logic [dda_pkg::COLOR_W-1:0]               pixel_color_i,
  input  logic                                      out_ready_i,
  output logic                                      out_valid_o,
  output logic [dda_pkg::PIX_W-1:0]                 pixel_x_o,
  output logic [dda_pkg::PIX_W-1:0]                 pixel_y_o,
  output logic [dda_pkg::COLOR_W-1:0]               color_out_o,
  output logic                                      last_pixel_o
);

  localparam int CoordW  = COORD_INT_BITS + COORD_FRAC_BITS;
  localparam int RndW    = COORD_INT_BITS + 1;
  localparam int RemW    = RndW + 1;
  localparam int ScaleSh = STEP_FRAC_BITS - COORD_FRAC_BITS;
  localparam int QuoW    = COORD_INT_BITS + STEP_FRAC_BITS;
  localparam int AccW    = QuoW + 1;
  localparam int LeftW   = $clog2(dda_pkg::MAX_RESULTS + 1);
  localparam int PixW    = dda_pkg::PIX_W;

  localparam logic [CoordW:0]   CoordHalf = (CoordW + 1)'((1 << COORD_FRAC_BITS) >> 1);
  localparam logic [AccW-1:0]   AccHalf   = AccW'(1) << (STEP_FRAC_BITS - 1);

  function automatic logic [RndW-1:0] round_coord(input logic [CoordW-1:0] v);
    logic [CoordW:0] sum;
    sum = {1'b0, v} + CoordHalf;
    return sum[CoordW:COORD_FRAC_BITS];
  endfunction

  logic [1:0][CoordW-1:0] start_w, end_w;
  logic [1:0][RndW-1:0]   rnd_span_w;
  logic [1:0][QuoW-1:0]   mag_w;
  logic [1:0]             neg_w;
  logic [1:0][AccW-1:0]   acc_init_w;
  logic [RndW-1:0]        count_w;
  logic [LeftW-1:0]       left_init_w;

  logic [RndW-1:0]              count_q;
  logic [1:0][QuoW-1:0]         div_q, div_d;
  logic [1:0][RndW-1:0]         rem_q, rem_d;
  logic [1:0]                   neg_q;
  logic [1:0][AccW-1:0]         acc_q, acc_d;
  logic [1:0][PixW-1:0]         pix_d;
  logic [LeftW-1:0]             left_q;
  logic [dda_pkg::COLOR_W-1:0]  color_q;
  logic                         out_valid_q;
  logic [PixW-1:0]              pix_x_q, pix_y_q;
  logic [dda_pkg::COLOR_W-1:0]  color_out_q;
  logic                         last_q;

  always_comb begin
    logic [RndW-1:0]   rs, re;
    logic [CoordW-1:0] ad;
    start_w[0] = start_x_i;
    start_w[1] = start_y_i;
    end_w[0]   = end_x_i;
    end_w[1]   = end_y_i;
    for (int l = 0; l < 2; l++) begin
      rs            = round_coord(start_w[l]);
      re            = round_coord(end_w[l]);
      rnd_span_w[l] = (rs > re) ? rs - re : re - rs;
      neg_w[l]      = end_w[l] < start_w[l];
      ad            = neg_w[l] ? start_w[l] - end_w[l] : end_w[l] - start_w[l];
      mag_w[l]      = QuoW'(ad) << ScaleSh;
      acc_init_w[l] = AccW'(start_w[l]) << ScaleSh;
    end
    count_w = (rnd_span_w[0] > rnd_span_w[1]) ? rnd_span_w[0] : rnd_span_w[1];
    if (32'(count_w) > 32'(dda_pkg::MAX_RESULTS)) begin
      left_init_w = LeftW'(dda_pkg::MAX_RESULTS);
    end else begin
      left_init_w = LeftW'(count_w);
    end
  end

  always_comb begin
    logic [RemW-1:0]      trial, diff;
    logic                 ge;
    logic [AccW-1:0]      rsum;
    logic [RndW-1:0]      rnd;
    logic [PixW+RndW-1:0] pad;
    for (int l = 0; l < 2; l++) begin
      trial    = {rem_q[l], div_q[l][QuoW-1]};
      diff     = trial - {1'b0, count_q};
      ge       = trial >= {1'b0, count_q};
      rem_d[l] = ge ? diff[RndW-1:0] : trial[RndW-1:0];
      div_d[l] = {div_q[l][QuoW-2:0], ge};

      rsum     = acc_q[l] + AccHalf;
      rnd      = acc_q[l][AccW-1] ? '0 : rsum[AccW-1:STEP_FRAC_BITS];
      pad      = {{PixW{1'b0}}, rnd};
      pix_d[l] = pad[PixW-1:0];
      acc_d[l] = neg_q[l] ? acc_q[l] - AccW'(div_q[l]) : acc_q[l] + AccW'(div_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      left_q      <= '0;
    end else begin
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        left_q <= left_init_w;
      end else if (cmd_i.emit) begin
        left_q <= left_q - LeftW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      count_q <= count_w;
      div_q   <= mag_w;
      rem_q   <= '0;
      neg_q   <= neg_w;
      acc_q   <= acc_init_w;
      color_q <= pixel_color_i;
    end else if (cmd_i.div_step) begin
      div_q <= div_d;
      rem_q <= rem_d;
    end else if (cmd_i.emit) begin
      acc_q       <= acc_d;
      pix_x_q     <= pix_d[0];
      pix_y_q     <= pix_d[1];
      color_out_q <= color_q;
      last_q      <= left_q == LeftW'(1);
    end
  end

  assign status_o.count_zero = count_w == '0;
  assign status_o.last       = left_q == LeftW'(1);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = pix_x_q;
  assign pixel_y_o    = pix_y_q;
  assign color_out_o  = color_out_q;
  assign last_pixel_o = last_q;

  a_emit_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_o)
    else $error("emitted pixel not presented");

  a_emit_counts_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> left_q == $past(left_q) - LeftW'(1))
    else $error("pixel count did not advance");

  a_last_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && status_o.last) |=> last_pixel_o)
    else $error("final pixel not marked");

endmodule

// File: hdl/dda_ctrl.sv
// Controller: sequences accept, bit-serial divide and pixel emission.
module dda_ctrl #(
  parameter int COORD_INT_BITS = dda_pkg::COORD_INT_BITS_DEF,
  parameter int STEP_FRAC_BITS = dda_pkg::STEP_FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dda_pkg::dda_status_t status_i,
  output dda_pkg::dda_cmd_t    cmd_o
);

  localparam int QuoW    = COORD_INT_BITS + STEP_FRAC_BITS;
  localparam int BitCntW = $clog2(QuoW);

  typedef enum logic [1:0] {
    StIdle,
    StDivide,
    StEmit
  } state_e;

  state_e             state_q;
  logic [BitCntW-1:0] bit_cnt_q;

  assign in_ready_o      = state_q == StIdle;
  assign cmd_o.load      = in_ready_o && in_valid_i;
  assign cmd_o.div_step  = state_q == StDivide;
  assign cmd_o.emit      = (state_q == StEmit) && status_i.out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      bit_cnt_q <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (cmd_o.load) begin
            bit_cnt_q <= BitCntW'(QuoW - 1);
            if (!status_i.count_zero) begin
              state_q <= StDivide;
            end
          end
        end
        StDivide: begin
          if (bit_cnt_q == '0) begin
            state_q <= StEmit;
          end else begin
            bit_cnt_q <= bit_cnt_q - BitCntW'(1);
          end
        end
        StEmit: begin
          if (cmd_o.emit && status_i.last) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  a_load_starts_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && !status_i.count_zero) |=> state_q == StDivide)
    else $error("segment did not start dividing");

  a_divide_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivide && bit_cnt_q == '0) |=> state_q == StEmit)
    else $error("divide did not hand over to emission");

  a_last_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && cmd_o.emit && status_i.last) |=> in_ready_o)
    else $error("input not reopened after final pixel");

endmodule

// File: hdl/dda_line_rasterizer_top.sv
// Top level of the DDA line rasterizer: controller plus datapath.
//
//   Channel  Valid / Ready            Payload
//   input    in_valid_i / in_ready_o  start_x_i start_y_i end_x_i end_y_i pixel_color_i
//   output   out_valid_o / out_ready_i  pixel_x_o pixel_y_o color_out_o last_pixel_o
//
// A segment is accepted, then divided bit-serially into a COORD_INT_BITS + STEP_FRAC_BITS bit
// quotient (22 bits by default, one quotient bit per cycle in both restoring divider lanes),
// and then emits min(count, 63) pixels.
// A zero-length segment is accepted but yields no pixel, and the input stays ready.
// Reset is asynchronous and needs no clearing pass.
// Emission holds while the output register is full and not taken; a new segment is
// accepted as soon as the final pixel is loaded, even while that pixel still waits.
module dda_line_rasterizer_top #(
  parameter int COORD_INT_BITS  = dda_pkg::COORD_INT_BITS_DEF,
  parameter int COORD_FRAC_BITS = dda_pkg::COORD_FRAC_BITS_DEF,
  parameter int STEP_FRAC_BITS  = dda_pkg::STEP_FRAC_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] start_x_i,
  input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] start_y_i,
  input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] end_x_i,
  input  logic [COORD_INT_BITS+COORD_FRAC_BITS-1:0] end_y_i,
  input  logic [dda_pkg::COLOR_W-1:0]               pixel_color_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic [dda_pkg::PIX_W-1:0]                 pixel_x_o,
  output logic [dda_pkg::PIX_W-1:0]                 pixel_y_o,
  output logic [dda_pkg::COLOR_W-1:0]               color_out_o,
  output logic                                      last_pixel_o
);

  dda_pkg::dda_cmd_t    cmd;
  dda_pkg::dda_status_t status;

  dda_ctrl #(
    .COORD_INT_BITS (COORD_INT_BITS),
    .STEP_FRAC_BITS (STEP_FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dda_datapath #(
    .COORD_INT_BITS  (COORD_INT_BITS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .STEP_FRAC_BITS  (STEP_FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .pixel_color_i (pixel_color_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .color_out_o   (color_out_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule
